FILE: sv/bvda_pkg.sv
// Shared types, constants and float helpers for the bf16 vector distance accumulator.
// No dependencies.
`default_nettype none

package bvda_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned Bf16Shift     = 16;
  localparam int unsigned CfgIdxW       = 2;

  localparam logic [CfgIdxW-1:0] REG_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_QFMT = 2'd1;

  localparam logic [31:0] QNAN      = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF   = 32'h7F80_0000;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

  typedef logic signed [12:0] exp_t;

  // Value = mant * 2^exp, mant msb at bit 61 when nonzero
  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [61:0] mant;
    exp_t        exp;
  } prod_t;

  typedef struct packed {
    logic [15:0] data;
    logic [31:0] query;
    logic        last;
    logic        mode;
  } item_t;

  typedef struct packed {
    prod_t p;
    logic  last;
  } qent_t;

  function automatic logic [5:0] msb_pos64(input logic [63:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [63:0] shift_jam64(input logic [63:0] m, input logic [12:0] n);
    logic [63:0] mask;
    logic [63:0] r;
    if (n >= 13'd64) begin
      r = {63'b0, |m};
    end else begin
      mask = ~({64{1'b1}} << n[5:0]);
      r = (m >> n[5:0]) | {63'b0, |(m & mask)};
    end
    return r;
  endfunction

  function automatic logic f_nan(input logic [31:0] x);
    return x[30:0] > POS_INF[30:0];
  endfunction

  function automatic logic f_inf(input logic [31:0] x);
    return x[30:0] == POS_INF[30:0];
  endfunction

  function automatic logic f_zero(input logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] unpack_mant(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
  endfunction

  function automatic exp_t unpack_exp(input logic [31:0] x);
    return (x[30:23] == 8'd0) ? exp_t'(-149) : (exp_t'({5'b0, x[30:23]}) - exp_t'(150));
  endfunction

endpackage

`default_nettype wire

FILE: sv/bvda_fadd.sv
// Four-stage adder: exact product plus binary32 addend, one RNE rounding.
// Depends on bvda_pkg.
`default_nettype none

module bvda_fadd
  import bvda_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        v_i,
  input  wire prod_t       p_i,
  input  wire logic [31:0] c_i,
  output logic             v_o,
  output logic [31:0]      res_o
);

  // stage 1: specials, align
  logic        v1_q, spec1_q, sp1_q, sc1_q;
  logic [31:0] sval1_q;
  logic [63:0] am1_q, bm1_q;
  exp_t        e1_q;
  // stage 2: add
  logic        v2_q, spec2_q, s2_q;
  logic [31:0] sval2_q;
  logic [63:0] m2_q;
  exp_t        e2_q;
  // stage 3: leading one
  logic        v3_q, spec3_q, s3_q;
  logic [31:0] sval3_q;
  logic [63:0] m3_q;
  exp_t        e3_q;
  logic [5:0]  pos3_q;
  // stage 4: rounded result
  logic        v4_q;
  logic [31:0] res4_q;

  logic        c_nan, c_inf, c_zero, sp, sc;
  logic        spec1_d;
  logic [31:0] sval1_d;
  logic [23:0] mc;
  logic [5:0]  pc;
  logic [63:0] mc_n, mp, am1_d, bm1_d;
  exp_t        ec_n, e1_d;

  always_comb begin
    c_nan  = f_nan(c_i);
    c_inf  = f_inf(c_i);
    c_zero = f_zero(c_i);
    sp     = p_i.sign;
    sc     = c_i[31];
    mc     = unpack_mant(c_i);
    pc     = msb_pos64({40'b0, mc});
    mc_n   = {40'b0, mc} << (6'd61 - pc);
    ec_n   = unpack_exp(c_i) - exp_t'({7'b0, 6'd61 - pc});
    mp     = {2'b0, p_i.mant};

    spec1_d = 1'b1;
    sval1_d = '0;
    if (p_i.nan || c_nan) begin
      sval1_d = QNAN;
    end else if (p_i.inf) begin
      sval1_d = (c_inf && (sc != sp)) ? QNAN : {sp, POS_INF[30:0]};
    end else if (c_inf) begin
      sval1_d = c_i;
    end else if (p_i.zero) begin
      sval1_d = c_zero ? ((sp == sc) ? c_i : 32'd0) : c_i;
    end else begin
      spec1_d = 1'b0;
    end

    if (c_zero) begin
      am1_d = mp;
      bm1_d = '0;
      e1_d  = p_i.exp;
    end else if (p_i.exp >= ec_n) begin
      am1_d = mp;
      bm1_d = shift_jam64(mc_n, 13'(p_i.exp - ec_n));
      e1_d  = p_i.exp;
    end else begin
      am1_d = shift_jam64(mp, 13'(ec_n - p_i.exp));
      bm1_d = mc_n;
      e1_d  = ec_n;
    end
  end

  logic [63:0] m2_d;
  logic        s2_d, spec2_d;
  logic [31:0] sval2_d;

  always_comb begin
    if (sp1_q == sc1_q) begin
      m2_d = am1_q + bm1_q;
      s2_d = sp1_q;
    end else if (am1_q >= bm1_q) begin
      m2_d = am1_q - bm1_q;
      s2_d = sp1_q;
    end else begin
      m2_d = bm1_q - am1_q;
      s2_d = sc1_q;
    end
    spec2_d = spec1_q;
    sval2_d = sval1_q;
    // exact cancellation gives +0
    if (!spec1_q && (m2_d == 64'd0)) begin
      spec2_d = 1'b1;
      sval2_d = 32'd0;
    end
  end

  exp_t        sh, lim, elsb, nsh, bexp;
  logic [63:0] mm, q, rem, half;
  logic [5:0]  shu;
  logic [33:0] total;
  logic [31:0] res4_d;

  always_comb begin
    sh  = exp_t'({7'b0, pos3_q}) - exp_t'(23);
    lim = exp_t'(-149) - e3_q;
    if (lim > sh) sh = lim;
    elsb = e3_q + sh;
    mm   = m3_q;
    nsh  = exp_t'(0) - sh;
    q    = '0;
    rem  = '0;
    half = '0;
    shu  = '0;
    if (sh <= exp_t'(0)) begin
      q = mm << nsh[5:0];
    end else begin
      if (sh > exp_t'(62)) begin
        mm = shift_jam64(mm, 13'(sh - exp_t'(62)));
        sh = exp_t'(62);
      end
      shu  = sh[5:0];
      q    = mm >> shu;
      rem  = mm & ~({64{1'b1}} << shu);
      half = 64'd1 << (shu - 6'd1);
      if ((rem > half) || ((rem == half) && q[0])) q = q + 64'd1;
    end
    bexp  = elsb + exp_t'(149);
    total = ({21'b0, bexp} << 23) + q[33:0];
    if (total >= {2'b0, POS_INF}) total = {2'b0, POS_INF};
    res4_d = spec3_q ? sval3_q : {s3_q, total[30:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= v_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec1_q <= spec1_d;
      sval1_q <= sval1_d;
      sp1_q   <= sp;
      sc1_q   <= sc;
      am1_q   <= am1_d;
      bm1_q   <= bm1_d;
      e1_q    <= e1_d;
      spec2_q <= spec2_d;
      sval2_q <= sval2_d;
      s2_q    <= s2_d;
      m2_q    <= m2_d;
      e2_q    <= e1_q;
      spec3_q <= spec2_q;
      sval3_q <= sval2_q;
      s3_q    <= s2_q;
      m3_q    <= m2_q;
      e3_q    <= e2_q;
      pos3_q  <= msb_pos64(m2_q);
      res4_q  <= res4_d;
    end
  end

  assign v_o   = v4_q;
  assign res_o = res4_q;

endmodule

`default_nettype wire

FILE: sv/bvda_front.sv
// Front pipeline: takes items, forms data - query in distance mode, then the exact
// normalized product. Depends on bvda_pkg and bvda_fadd.
`default_nettype none

module bvda_front
  import bvda_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        mode_i,
  input  wire logic        qfmt_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] data_value_i,
  input  wire logic [31:0] query_value_i,
  input  wire logic        last_element_i,
  output logic             push_o,
  input  wire logic        full_i,
  output qent_t            push_data_o
);

  logic        en;
  logic        s0_v_q;
  item_t       s0_q;
  item_t       side_q [4];
  logic        dv;
  logic [31:0] diff;

  // stage 5: raw product
  logic        s5_v_q, s5_last_q;
  logic        s5_sign_q, s5_nan_q, s5_inf_q, s5_zero_q;
  logic [47:0] s5_m_q;
  exp_t        s5_e_q;
  // stage 6: normalized product
  logic        s6_v_q;
  qent_t       s6_q;

  // stall everything while a finished product cannot enter the queue
  assign en          = !s6_v_q || !full_i;
  assign in_ready_o  = en;
  assign push_o      = s6_v_q && !full_i;
  assign push_data_o = s6_q;

  prod_t       dprod;
  logic [31:0] d32;
  logic [23:0] md;
  logic [5:0]  pd;

  always_comb begin
    d32         = {s0_q.data, 16'b0};
    md          = unpack_mant(d32);
    pd          = msb_pos64({40'b0, md});
    dprod.sign  = d32[31];
    dprod.nan   = f_nan(d32);
    dprod.inf   = f_inf(d32);
    dprod.zero  = f_zero(d32);
    dprod.mant  = 62'({38'b0, md} << (6'd61 - pd));
    dprod.exp   = unpack_exp(d32) - exp_t'({7'b0, 6'd61 - pd});
  end

  bvda_fadd u_diff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .v_i    (s0_v_q),
    .p_i    (dprod),
    .c_i    (s0_q.query ^ SIGN_MASK),
    .v_o    (dv),
    .res_o  (diff)
  );

  logic [31:0] a, b;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic        m_nan, m_inf, m_zero;

  always_comb begin
    a      = side_q[3].mode ? diff : {side_q[3].data, 16'b0};
    b      = side_q[3].mode ? diff : side_q[3].query;
    nan_a  = f_nan(a);
    nan_b  = f_nan(b);
    inf_a  = f_inf(a);
    inf_b  = f_inf(b);
    zero_a = f_zero(a);
    zero_b = f_zero(b);
    m_nan  = nan_a || nan_b || ((inf_a || inf_b) && (zero_a || zero_b));
    m_inf  = !m_nan && (inf_a || inf_b);
    m_zero = !m_nan && !m_inf && (zero_a || zero_b);
  end

  logic [5:0] p6;
  qent_t      s6_d;

  always_comb begin
    p6            = msb_pos64({16'b0, s5_m_q});
    s6_d.last     = s5_last_q;
    s6_d.p.sign   = s5_sign_q;
    s6_d.p.nan    = s5_nan_q;
    s6_d.p.inf    = s5_inf_q;
    s6_d.p.zero   = s5_zero_q;
    s6_d.p.mant   = {14'b0, s5_m_q} << (6'd61 - p6);
    s6_d.p.exp    = s5_e_q - exp_t'({7'b0, 6'd61 - p6});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_valid_i;
      s5_v_q <= dv;
      s6_v_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q.data  <= data_value_i;
      s0_q.query <= qfmt_i ? {query_value_i[15:0], 16'b0} : query_value_i;
      s0_q.last  <= last_element_i;
      s0_q.mode  <= mode_i;
      side_q[0]  <= s0_q;
      for (int i = 1; i < 4; i++) begin
        side_q[i] <= side_q[i-1];
      end
      s5_last_q <= side_q[3].last;
      s5_sign_q <= a[31] ^ b[31];
      s5_nan_q  <= m_nan;
      s5_inf_q  <= m_inf;
      s5_zero_q <= m_zero;
      s5_m_q    <= unpack_mant(a) * unpack_mant(b);
      s5_e_q    <= unpack_exp(a) + unpack_exp(b);
      s6_q      <= s6_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bvda_queue.sv
// Small FIFO of normalized products between the front and back parts.
// Depends on bvda_pkg.
`default_nettype none

module bvda_queue
  import bvda_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output qent_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qent_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= next_ptr(wr_q);
      if (pop_i) rd_q <= next_ptr(rd_q);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

FILE: sv/bvda_back.sv
// Back part: adds each queued product into the running sum, emits the sum on last.
// Depends on bvda_pkg and bvda_fadd.
`default_nettype none

module bvda_back
  import bvda_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  empty_i,
  input  wire qent_t head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic [31:0] distance_o
);

  logic        busy_q, last_q, out_valid_q;
  logic [31:0] sum_q, out_q;
  logic        issue, res_v;
  logic [31:0] res;

  // a last item waits until the output register is free
  assign issue = !busy_q && !empty_i && (!head_i.last || !out_valid_q);
  assign pop_o = issue;

  bvda_fadd u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (1'b1),
    .v_i    (issue),
    .p_i    (head_i.p),
    .c_i    (sum_q),
    .v_o    (res_v),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      if (issue) begin
        busy_q <= 1'b1;
        last_q <= head_i.last;
      end else if (res_v) begin
        busy_q <= 1'b0;
      end
      if (res_v) begin
        sum_q <= last_q ? 32'd0 : res;
      end
      if (res_v && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_v && last_q) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_q;

  a_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> !busy_q)
    else $error("issue while add in flight");

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v |-> busy_q)
    else $error("add result without pending item");

  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v && last_q) |=> (sum_q == 32'd0) && out_valid_q)
    else $error("sum not cleared or result not shown after last item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v && last_q) |-> !out_valid_q)
    else $error("result register overwritten");

endmodule

`default_nettype wire

FILE: sv/bf16_vector_distance_accumulator.sv
// Top level of the bf16 vector distance accumulator: config registers, front, queue, back.
// Depends on bvda_pkg, bvda_front, bvda_queue, bvda_back.
`default_nettype none

// Accumulates a dot product (mode 0) or squared L2 distance (mode 1) over a stream of
// bfloat16 data / float32-or-bfloat16 query pairs, in arrival order, with binary32 RNE
// fused multiply-add per element; the item flagged last yields the sum and clears it.
// The front pipeline takes one item per cycle while the queue can accept its products
// and stalls as a whole when it cannot. The back part adds one queued product at a
// time into the running sum through its 4-stage add unit, taking the next product only
// after the previous sum is written back; once the queue fills, the input is held off.
// Registers: index 0 mode, index 1 query format (1 = bfloat16 in bits 15..0).
module bf16_vector_distance_accumulator
  import bvda_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic               cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [15:0]        data_value_i,
  input  wire logic [31:0]        query_value_i,
  input  wire logic               last_element_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [31:0]             distance_o
);

  logic  mode_q, qfmt_q;
  logic  push, full, pop, empty;
  qent_t push_data, head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      qfmt_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE: mode_q <= cfg_data_i;
        REG_QFMT: qfmt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bvda_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .qfmt_i         (qfmt_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_value_i   (data_value_i),
    .query_value_i  (query_value_i),
    .last_element_i (last_element_i),
    .push_o         (push),
    .full_i         (full),
    .push_data_o    (push_data)
  );

  bvda_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  bvda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .distance_o  (distance_o)
  );

endmodule

`default_nettype wire
